FILE: rtl/distance_constraint_relax_assert.svh
// Assertion macros used by the top-level RTL of the link relaxation block.
`ifndef DISTANCE_CONSTRAINT_RELAX_ASSERT_SVH
`define DISTANCE_CONSTRAINT_RELAX_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define DCR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("distance_constraint_relax: same-cycle check failed");

// Consequent checked in the cycle after the antecedent.
`define DCR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("distance_constraint_relax: next-cycle check failed");

`endif

FILE: rtl/dcr_pkg.sv
`timescale 1ns / 1ps
package dcr_pkg;

  localparam int POS_W     = 32;
  localparam int DLT_W     = 33;
  localparam int MASS_W    = 16;
  localparam int MSUM_W    = 17;
  localparam int REST_W    = 31;
  localparam int ST_W      = 17;
  localparam int TEAR_W    = 31;
  localparam int SQ_W      = 66;
  localparam int ROOT_W    = 33;
  localparam int WNUM_W    = ST_W + MASS_W;
  localparam int W_FRAC    = 16;
  localparam int CAP_EXP   = 62;
  localparam int LANE_LAT  = 6;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 31;

  localparam logic [ST_W-1:0]   ST_RESET   = 17'h10000;
  localparam logic [TEAR_W-1:0] TEAR_RESET = 31'h7fffffff;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STIFFNESS = 1'b0,
    CFG_TEAR      = 1'b1
  } cfg_idx_t;

  typedef logic signed [POS_W-1:0] pos_t;
  typedef logic signed [DLT_W-1:0] dlt_t;
  typedef logic [MASS_W-1:0]       mass_t;
  typedef logic [REST_W-1:0]       rest_t;
  typedef logic [ST_W-1:0]         wgt_t;

  typedef struct packed {
    pos_t x1;
    pos_t y1;
    pos_t z1;
    pos_t x2;
    pos_t y2;
    pos_t z2;
  } pos6_t;

  typedef struct packed {
    pos6_t pos;
    mass_t m1;
    mass_t m2;
    rest_t rest;
  } item_t;

  typedef struct packed {
    dlt_t  dx;
    dlt_t  dy;
    dlt_t  dz;
    rest_t rest;
    logic  mzero;
  } geo_t;

  typedef struct packed {
    wgt_t  w1;
    wgt_t  w2;
    logic  dneg;
    logic  torn;
    logic  degen;
    dlt_t  dx;
    dlt_t  dy;
    dlt_t  dz;
    pos6_t pos;
  } corr_side_t;

  function automatic logic [DLT_W-1:0] dlt_mag(input dlt_t v);
    logic [DLT_W-1:0] m;
    m = v[DLT_W-1] ? DLT_W'(-v) : DLT_W'(v);
    return m;
  endfunction

endpackage

FILE: rtl/dcr_sqrt.sv
`timescale 1ns / 1ps
module dcr_sqrt #(
  parameter int SB_W = 1
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic [dcr_pkg::SQ_W-1:0]     radicand,
  input  logic [SB_W-1:0]              sb_in,
  output logic                         out_valid,
  output logic [dcr_pkg::ROOT_W-1:0]   root,
  output logic [SB_W-1:0]              sb_out
);
  import dcr_pkg::*;

  localparam int REM_W = ROOT_W + 2;

  logic [ROOT_W-1:0] v;
  logic [SQ_W-1:0]   rad [ROOT_W];
  logic [REM_W-1:0]  rm  [ROOT_W];
  logic [ROOT_W-1:0] rt  [ROOT_W];
  logic [SB_W-1:0]   sb  [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    logic              vi;
    logic [SQ_W-1:0]   ri;
    logic [REM_W-1:0]  mi;
    logic [ROOT_W-1:0] ti;
    logic [SB_W-1:0]   si;
    logic [REM_W+1:0]  sh;
    logic [REM_W+1:0]  trial;
    logic              ge;

    if (k == 0) begin : g_head
      assign vi = in_valid;
      assign ri = radicand;
      assign mi = '0;
      assign ti = '0;
      assign si = sb_in;
    end else begin : g_body
      assign vi = v[k-1];
      assign ri = rad[k-1];
      assign mi = rm[k-1];
      assign ti = rt[k-1];
      assign si = sb[k-1];
    end

    assign sh    = {mi, ri[SQ_W-1 -: 2]};
    assign trial = {2'b00, ti, 2'b01};
    assign ge    = sh >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (en) begin
        v[k] <= vi;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad[k] <= ri << 2;
        rm[k]  <= ge ? REM_W'(sh - trial) : sh[REM_W-1:0];
        rt[k]  <= {ti[ROOT_W-2:0], ge};
        sb[k]  <= si;
      end
    end
  end

  assign out_valid = v[ROOT_W-1];
  assign root      = rt[ROOT_W-1];
  assign sb_out    = sb[ROOT_W-1];

endmodule

FILE: rtl/dcr_div.sv
`timescale 1ns / 1ps
module dcr_div #(
  parameter int NUM_W = 33,
  parameter int DEN_W = 17,
  parameter int SB_W  = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  input  logic [SB_W-1:0]  sb_in,
  output logic             out_valid,
  output logic [NUM_W-1:0] quo,
  output logic [DEN_W-1:0] rem,
  output logic [SB_W-1:0]  sb_out
);

  logic [NUM_W-1:0] v;
  logic [NUM_W-1:0] qn [NUM_W];
  logic [DEN_W-1:0] rm [NUM_W];
  logic [DEN_W-1:0] dn [NUM_W];
  logic [SB_W-1:0]  sb [NUM_W];

  for (genvar k = 0; k < NUM_W; k++) begin : g_stage
    logic             vi;
    logic [NUM_W-1:0] qi;
    logic [DEN_W-1:0] ri;
    logic [DEN_W-1:0] di;
    logic [SB_W-1:0]  si;
    logic [DEN_W:0]   rs;
    logic             ge;

    if (k == 0) begin : g_head
      assign vi = in_valid;
      assign qi = num;
      assign ri = '0;
      assign di = den;
      assign si = sb_in;
    end else begin : g_body
      assign vi = v[k-1];
      assign qi = qn[k-1];
      assign ri = rm[k-1];
      assign di = dn[k-1];
      assign si = sb[k-1];
    end

    assign rs = {ri, qi[NUM_W-1]};
    assign ge = rs >= {1'b0, di};

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (en) begin
        v[k] <= vi;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        qn[k] <= {qi[NUM_W-2:0], ge};
        rm[k] <= ge ? DEN_W'(rs - {1'b0, di}) : rs[DEN_W-1:0];
        dn[k] <= di;
        sb[k] <= si;
      end
    end
  end

  assign out_valid = v[NUM_W-1];
  assign quo       = qn[NUM_W-1];
  assign rem       = rm[NUM_W-1];
  assign sb_out    = sb[NUM_W-1];

endmodule

FILE: rtl/dcr_corr.sv
`timescale 1ns / 1ps
module dcr_corr #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  en,
  input  dcr_pkg::dlt_t                         delta,
  input  dcr_pkg::wgt_t                         w,
  input  logic [dcr_pkg::DLT_W+FRAC_BITS-1:0]   dmag,
  input  logic                                  dneg,
  input  logic                                  sub,
  input  logic                                  hold,
  input  dcr_pkg::pos_t                         pos,
  output dcr_pkg::pos_t                         result
);
  import dcr_pkg::*;

  localparam int BW    = DLT_W + FRAC_BITS;
  localparam int AW    = DLT_W + ST_W;
  localparam int PW    = AW + BW;
  localparam int H     = (BW + 1) / 2;
  localparam int AHW   = AW - H;
  localparam int BHW   = BW - H;
  localparam int CW    = PW - H;
  localparam int SHIFT = W_FRAC + FRAC_BITS;
  localparam int OW    = PW - SHIFT;
  localparam logic [OW-1:0] CAP = OW'(1) << CAP_EXP;

  logic [DLT_W-1:0] mag;
  logic [AW-1:0]    s1_a;
  logic [BW-1:0]    s1_dm;
  logic [AHW+BHW-1:0] s2_hh;
  logic [AW-1:0]    s2_hl;
  logic [BW-1:0]    s2_lh;
  logic [2*H-1:0]   s2_ll;
  logic [CW-1:0]    s3_cr;
  logic [AHW+BHW-1:0] s3_hh;
  logic [2*H-1:0]   s3_ll;
  logic [PW-1:0]    s4_tot;
  logic [OW-1:0]    ov;
  logic [OW-1:0]    capped;
  logic signed [63:0] s5_cv;
  logic signed [64:0] sm;
  logic [3:0]       ng;
  logic [4:0]       hd;
  pos_t             ps [5];

  assign mag = dlt_mag(delta);

  always_ff @(posedge clk) begin
    if (en) begin
      s1_a  <= {{ST_W{1'b0}}, mag} * {{DLT_W{1'b0}}, w};
      s1_dm <= dmag;
      ng[0] <= delta[DLT_W-1] ^ dneg ^ sub;
      hd[0] <= hold;
      ps[0] <= pos;
      for (int i = 1; i < 5; i++) begin
        hd[i] <= hd[i-1];
        ps[i] <= ps[i-1];
      end
      for (int i = 1; i < 4; i++) begin
        ng[i] <= ng[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_hh <= {{BHW{1'b0}}, s1_a[AW-1:H]} * {{AHW{1'b0}}, s1_dm[BW-1:H]};
      s2_hl <= {{H{1'b0}}, s1_a[AW-1:H]} * {{AHW{1'b0}}, s1_dm[H-1:0]};
      s2_lh <= {{BHW{1'b0}}, s1_a[H-1:0]} * {{H{1'b0}}, s1_dm[BW-1:H]};
      s2_ll <= {{H{1'b0}}, s1_a[H-1:0]} * {{H{1'b0}}, s1_dm[H-1:0]};
      s3_cr <= {{BHW{1'b0}}, s2_hl} + {{AHW{1'b0}}, s2_lh};
      s3_hh <= s2_hh;
      s3_ll <= s2_ll;
      s4_tot <= {s3_hh, s3_ll} + {s3_cr, {H{1'b0}}};
    end
  end

  assign ov     = s4_tot[PW-1:SHIFT];
  assign capped = (ov > CAP) ? CAP : ov;
  assign sm     = {{33{ps[4][POS_W-1]}}, ps[4]} + {s5_cv[63], s5_cv};

  always_ff @(posedge clk) begin
    if (en) begin
      s5_cv <= ng[3] ? -$signed(capped[63:0]) : $signed(capped[63:0]);
      if (hd[4]) begin
        result <= ps[4];
      end else if (sm[64] && !(&sm[63:31])) begin
        result <= {1'b1, {(POS_W-1){1'b0}}};
      end else if (!sm[64] && (|sm[63:31])) begin
        result <= {1'b0, {(POS_W-1){1'b1}}};
      end else begin
        result <= sm[POS_W-1:0];
      end
    end
  end

endmodule

FILE: rtl/distance_constraint_relax.sv
// Path: input, difference, square and sum registers, square root and weight divider,
// distance divider, correction lanes; a link taken in a stall waits in the skid first.
// Throughput: one link per cycle unless out_ready stalls; the square root, both dividers
// and the six lanes are fully pipelined, one bit or one partial-product step per stage.
// Reset clears all valid bits and the skid-full flag and loads stiffness 1.0 and the
// largest tear distance.
`timescale 1ns / 1ps
`include "distance_constraint_relax_assert.svh"
module distance_constraint_relax #(
  parameter int FRAC_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [dcr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dcr_pkg::CFG_W-1:0]        cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [dcr_pkg::POS_W-1:0] first_x,
  input  logic signed [dcr_pkg::POS_W-1:0] first_y,
  input  logic signed [dcr_pkg::POS_W-1:0] first_z,
  input  logic signed [dcr_pkg::POS_W-1:0] second_x,
  input  logic signed [dcr_pkg::POS_W-1:0] second_y,
  input  logic signed [dcr_pkg::POS_W-1:0] second_z,
  input  logic [dcr_pkg::MASS_W-1:0]       first_mass,
  input  logic [dcr_pkg::MASS_W-1:0]       second_mass,
  input  logic [dcr_pkg::REST_W-1:0]       rest_length,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [dcr_pkg::POS_W-1:0] new_first_x,
  output logic signed [dcr_pkg::POS_W-1:0] new_first_y,
  output logic signed [dcr_pkg::POS_W-1:0] new_first_z,
  output logic signed [dcr_pkg::POS_W-1:0] new_second_x,
  output logic signed [dcr_pkg::POS_W-1:0] new_second_y,
  output logic signed [dcr_pkg::POS_W-1:0] new_second_z,
  output logic                             torn,
  output logic                             degenerate
);
  import dcr_pkg::*;

  localparam int BW = DLT_W + FRAC_BITS;

  logic [ST_W-1:0]   stiffness;
  logic [TEAR_W-1:0] tear_distance;

  logic  en;
  logic  skid_full;
  item_t in_item;
  item_t skid_item;
  item_t a_item;
  logic  a_valid;

  logic  b_valid;
  dlt_t  b_dx, b_dy, b_dz;
  pos6_t b_pos;
  rest_t b_rest;
  logic [WNUM_W-1:0] b_wnum;
  logic [MSUM_W-1:0] b_msum;

  logic  c_valid;
  logic [SQ_W-1:0] c_sqx, c_sqy;
  dlt_t  c_dx, c_dy, c_dz;
  pos6_t c_pos;
  rest_t c_rest;
  logic [WNUM_W-1:0] c_wnum;
  logic [MSUM_W-1:0] c_msum;

  logic  d_valid;
  logic [SQ_W-1:0] d_sum;
  geo_t  d_geo;
  pos6_t d_pos;
  logic [WNUM_W-1:0] d_wnum;
  logic [MSUM_W-1:0] d_msum;

  logic  sq_valid;
  logic [ROOT_W-1:0] sq_root;
  geo_t  sq_geo;
  logic  wd_valid;
  logic [WNUM_W-1:0] wd_quo;
  logic [MSUM_W-1:0] wd_rem;
  pos6_t wd_pos;

  wgt_t  q_w;
  logic [ROOT_W-1:0] rest_ext;
  logic  dneg_c;
  logic [ROOT_W-1:0] mag_c;

  logic  e_valid;
  logic [BW-1:0] e_num;
  logic [ROOT_W-1:0] e_den;
  corr_side_t e_side;

  logic  f_valid;
  logic [BW-1:0] f_quo;
  corr_side_t f_side;

  logic [LANE_LAT-1:0] lv;
  logic [LANE_LAT-1:0] torn_q;
  logic [LANE_LAT-1:0] degen_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      stiffness     <= ST_RESET;
      tear_distance <= TEAR_RESET;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_STIFFNESS: stiffness     <= cfg_data[ST_W-1:0];
        CFG_TEAR:      tear_distance <= cfg_data[TEAR_W-1:0];
        default: ;
      endcase
    end
  end

  assign en       = !out_valid || out_ready;
  assign in_ready = !skid_full;

  always_comb begin
    in_item.pos.x1 = first_x;
    in_item.pos.y1 = first_y;
    in_item.pos.z1 = first_z;
    in_item.pos.x2 = second_x;
    in_item.pos.y2 = second_y;
    in_item.pos.z2 = second_z;
    in_item.m1     = first_mass;
    in_item.m2     = second_mass;
    in_item.rest   = rest_length;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      skid_full <= 1'b0;
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      c_valid   <= 1'b0;
      d_valid   <= 1'b0;
      e_valid   <= 1'b0;
    end else begin
      if (en) begin
        a_valid   <= skid_full || in_valid;
        skid_full <= 1'b0;
        b_valid   <= a_valid;
        c_valid   <= b_valid;
        d_valid   <= c_valid;
        e_valid   <= sq_valid;
      end else if (in_valid && in_ready) begin
        skid_full <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!en && in_ready) begin
      skid_item <= in_item;
    end
    if (en) begin
      a_item <= skid_full ? skid_item : in_item;

      b_dx   <= {a_item.pos.x1[POS_W-1], a_item.pos.x1} - {a_item.pos.x2[POS_W-1], a_item.pos.x2};
      b_dy   <= {a_item.pos.y1[POS_W-1], a_item.pos.y1} - {a_item.pos.y2[POS_W-1], a_item.pos.y2};
      b_dz   <= {a_item.pos.z1[POS_W-1], a_item.pos.z1} - {a_item.pos.z2[POS_W-1], a_item.pos.z2};
      b_pos  <= a_item.pos;
      b_rest <= a_item.rest;
      b_wnum <= {{MASS_W{1'b0}}, stiffness} * {{ST_W{1'b0}}, a_item.m2};
      b_msum <= {1'b0, a_item.m1} + {1'b0, a_item.m2};

      c_sqx  <= {{DLT_W{1'b0}}, dlt_mag(b_dx)} * {{DLT_W{1'b0}}, dlt_mag(b_dx)};
      c_sqy  <= {{DLT_W{1'b0}}, dlt_mag(b_dy)} * {{DLT_W{1'b0}}, dlt_mag(b_dy)};
      c_dx   <= b_dx;
      c_dy   <= b_dy;
      c_dz   <= b_dz;
      c_pos  <= b_pos;
      c_rest <= b_rest;
      c_wnum <= b_wnum;
      c_msum <= b_msum;

      d_sum       <= c_sqx + c_sqy;
      d_geo.dx    <= c_dx;
      d_geo.dy    <= c_dy;
      d_geo.dz    <= c_dz;
      d_geo.rest  <= c_rest;
      d_geo.mzero <= c_msum == '0;
      d_pos       <= c_pos;
      d_wnum      <= c_wnum;
      d_msum      <= c_msum;
    end
  end

  dcr_sqrt #(
    .SB_W($bits(geo_t))
  ) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (d_valid),
    .radicand  (d_sum),
    .sb_in     (d_geo),
    .out_valid (sq_valid),
    .root      (sq_root),
    .sb_out    (sq_geo)
  );

  dcr_div #(
    .NUM_W (WNUM_W),
    .DEN_W (MSUM_W),
    .SB_W  ($bits(pos6_t))
  ) u_wdiv (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (d_valid),
    .num       (d_wnum),
    .den       (d_msum),
    .sb_in     (d_pos),
    .out_valid (wd_valid),
    .quo       (wd_quo),
    .rem       (wd_rem),
    .sb_out    (wd_pos)
  );

  assign q_w      = wd_quo[ST_W-1:0];
  assign rest_ext = {{(ROOT_W-REST_W){1'b0}}, sq_geo.rest};
  assign dneg_c   = rest_ext < sq_root;
  assign mag_c    = dneg_c ? sq_root - rest_ext : rest_ext - sq_root;

  always_ff @(posedge clk) begin
    if (en) begin
      e_num        <= {mag_c, {FRAC_BITS{1'b0}}};
      e_den        <= sq_root;
      e_side.w1    <= sq_geo.mzero ? '0 : q_w;
      e_side.w2    <= sq_geo.mzero ? '0 : stiffness - q_w - ST_W'(wd_rem != '0);
      e_side.dneg  <= dneg_c;
      e_side.torn  <= sq_root > {{(ROOT_W-TEAR_W){1'b0}}, tear_distance};
      e_side.degen <= sq_root == '0;
      e_side.dx    <= sq_geo.dx;
      e_side.dy    <= sq_geo.dy;
      e_side.dz    <= sq_geo.dz;
      e_side.pos   <= wd_pos;
    end
  end

  dcr_div #(
    .NUM_W (BW),
    .DEN_W (ROOT_W),
    .SB_W  ($bits(corr_side_t))
  ) u_ddiv (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (e_valid),
    .num       (e_num),
    .den       (e_den),
    .sb_in     (e_side),
    .out_valid (f_valid),
    .quo       (f_quo),
    .rem       (),
    .sb_out    (f_side)
  );

  dcr_corr #(.FRAC_BITS(FRAC_BITS)) u_lane_x1 (
    .clk(clk), .en(en), .delta(f_side.dx), .w(f_side.w1), .dmag(f_quo),
    .dneg(f_side.dneg), .sub(1'b0), .hold(f_side.degen), .pos(f_side.pos.x1),
    .result(new_first_x)
  );

  dcr_corr #(.FRAC_BITS(FRAC_BITS)) u_lane_y1 (
    .clk(clk), .en(en), .delta(f_side.dy), .w(f_side.w1), .dmag(f_quo),
    .dneg(f_side.dneg), .sub(1'b0), .hold(f_side.degen), .pos(f_side.pos.y1),
    .result(new_first_y)
  );

  dcr_corr #(.FRAC_BITS(FRAC_BITS)) u_lane_z1 (
    .clk(clk), .en(en), .delta(f_side.dz), .w(f_side.w1), .dmag(f_quo),
    .dneg(f_side.dneg), .sub(1'b0), .hold(f_side.degen), .pos(f_side.pos.z1),
    .result(new_first_z)
  );

  dcr_corr #(.FRAC_BITS(FRAC_BITS)) u_lane_x2 (
    .clk(clk), .en(en), .delta(f_side.dx), .w(f_side.w2), .dmag(f_quo),
    .dneg(f_side.dneg), .sub(1'b1), .hold(f_side.degen), .pos(f_side.pos.x2),
    .result(new_second_x)
  );

  dcr_corr #(.FRAC_BITS(FRAC_BITS)) u_lane_y2 (
    .clk(clk), .en(en), .delta(f_side.dy), .w(f_side.w2), .dmag(f_quo),
    .dneg(f_side.dneg), .sub(1'b1), .hold(f_side.degen), .pos(f_side.pos.y2),
    .result(new_second_y)
  );

  dcr_corr #(.FRAC_BITS(FRAC_BITS)) u_lane_z2 (
    .clk(clk), .en(en), .delta(f_side.dz), .w(f_side.w2), .dmag(f_quo),
    .dneg(f_side.dneg), .sub(1'b1), .hold(f_side.degen), .pos(f_side.pos.z2),
    .result(new_second_z)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      lv <= '0;
    end else if (en) begin
      lv <= {lv[LANE_LAT-2:0], f_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      torn_q  <= {torn_q[LANE_LAT-2:0], f_side.torn};
      degen_q <= {degen_q[LANE_LAT-2:0], f_side.degen};
    end
  end

  assign out_valid  = lv[LANE_LAT-1];
  assign torn       = torn_q[LANE_LAT-1];
  assign degenerate = degen_q[LANE_LAT-1];

  `DCR_ASSERT_NEXT(a_skid_fill, in_valid && in_ready && !en, skid_full)
  `DCR_ASSERT_NEXT(a_skid_drain, en && skid_full, !skid_full && a_valid)
  `DCR_ASSERT_NOW(a_unit_align, 1'b1, sq_valid == wd_valid)
  `DCR_ASSERT_NOW(a_flag_excl, out_valid && degenerate, !torn)

endmodule

FILE: dv/distance_constraint_relax_tb.sv
`timescale 1ns / 1ps
module distance_constraint_relax_tb;
  import dcr_pkg::*;

  localparam int FRAC = 16;
  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_CYCLES = 120;

  typedef struct {
    pos_t  p1 [3];
    pos_t  p2 [3];
    mass_t m1;
    mass_t m2;
    rest_t rest;
  } link_t;

  typedef struct {
    pos_t q1 [3];
    pos_t q2 [3];
    logic tear;
    logic degen;
  } relaxed_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  pos_t first_x = '0, first_y = '0, first_z = '0;
  pos_t second_x = '0, second_y = '0, second_z = '0;
  mass_t first_mass = 16'd1, second_mass = 16'd1;
  rest_t rest_length = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  pos_t new_first_x, new_first_y, new_first_z;
  pos_t new_second_x, new_second_y, new_second_z;
  logic torn, degenerate;

  logic [ST_W-1:0] stiffness_reg;
  logic [TEAR_W-1:0] tear_reg;
  relaxed_t pending_results[$];
  int errors = 0;
  int cycles = 0;
  int send_idle = 0;
  int recv_idle = 0;
  int hold_left = 0;

  distance_constraint_relax #(.FRAC_BITS(FRAC)) dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .first_x(first_x), .first_y(first_y), .first_z(first_z),
    .second_x(second_x), .second_y(second_y), .second_z(second_z),
    .first_mass(first_mass), .second_mass(second_mass), .rest_length(rest_length),
    .out_valid(out_valid), .out_ready(out_ready),
    .new_first_x(new_first_x), .new_first_y(new_first_y), .new_first_z(new_first_z),
    .new_second_x(new_second_x), .new_second_y(new_second_y),
    .new_second_z(new_second_z), .torn(torn), .degenerate(degenerate)
  );

  always #2 clk = ~clk;

  function automatic pos_t clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return pos_t'(v);
  endfunction

  function automatic longint shift_amount(logic signed [32:0] dl, logic [16:0] w,
                                          logic dneg, logic [127:0] dmag);
    logic [127:0] mag;
    logic [127:0] prod;
    mag = dl[32] ? 128'(-dl) : 128'(dl);
    prod = (mag * 128'(w) * dmag) >> (W_FRAC + FRAC);
    if (prod > (128'd1 << 62)) prod = 128'd1 << 62;
    return ((dl < 0) != dneg) ? -longint'(prod[63:0]) : longint'(prod[63:0]);
  endfunction

  function automatic relaxed_t relax_link(link_t l);
    relaxed_t r;
    logic signed [32:0] dl [3];
    logic [127:0] mx, my, sq, root, cand, d, dmag;
    logic [16:0] msum, w1, w2;
    logic dneg;
    for (int i = 0; i < 3; i++) dl[i] = 33'(l.p1[i]) - 33'(l.p2[i]);
    mx = dl[0][32] ? 128'(-dl[0]) : 128'(dl[0]);
    my = dl[1][32] ? 128'(-dl[1]) : 128'(dl[1]);
    sq = mx * mx + my * my;
    root = '0;
    for (int b = 33; b >= 0; b--) begin
      cand = root | (128'd1 << b);
      if (cand * cand <= sq) root = cand;
    end
    d = root;
    r.tear = d > 128'(tear_reg);
    r.degen = d == 0;
    r.q1 = l.p1;
    r.q2 = l.p2;
    if (r.degen) return r;
    dneg = 128'(l.rest) < d;
    dmag = ((dneg ? d - 128'(l.rest) : 128'(l.rest) - d) << FRAC) / d;
    msum = 17'(l.m1) + 17'(l.m2);
    w1 = '0;
    w2 = '0;
    if (msum != 0) begin
      w1 = 17'((34'(stiffness_reg) * 34'(l.m2)) / 34'(msum));
      w2 = 17'((34'(stiffness_reg) * 34'(l.m1)) / 34'(msum));
    end
    for (int i = 0; i < 3; i++) begin
      r.q1[i] = clamp32(longint'(l.p1[i]) + shift_amount(dl[i], w1, dneg, dmag));
      r.q2[i] = clamp32(longint'(l.p2[i]) - shift_amount(dl[i], w2, dneg, dmag));
    end
    return r;
  endfunction

  task automatic report(string field, longint got, longint want);
    $display("mismatch on %s: got %0d, expected %0d", field, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (hold_left > 0) hold_left <= hold_left - 1;
    out_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    relaxed_t e;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report("unexpected result transfer", 1, 0);
      end else begin
        e = pending_results.pop_front();
        if (new_first_x !== e.q1[0]) report("new_first_x", new_first_x, e.q1[0]);
        if (new_first_y !== e.q1[1]) report("new_first_y", new_first_y, e.q1[1]);
        if (new_first_z !== e.q1[2]) report("new_first_z", new_first_z, e.q1[2]);
        if (new_second_x !== e.q2[0]) report("new_second_x", new_second_x, e.q2[0]);
        if (new_second_y !== e.q2[1]) report("new_second_y", new_second_y, e.q2[1]);
        if (new_second_z !== e.q2[2]) report("new_second_z", new_second_z, e.q2[2]);
        if (torn !== e.tear) report("torn", torn, e.tear);
        if (degenerate !== e.degen) report("degenerate", degenerate, e.degen);
      end
    end
  end

  task automatic send_link(link_t l);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    first_x <= l.p1[0];
    first_y <= l.p1[1];
    first_z <= l.p1[2];
    second_x <= l.p2[0];
    second_y <= l.p2[1];
    second_z <= l.p2[2];
    first_mass <= l.m1;
    second_mass <= l.m2;
    rest_length <= l.rest;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(relax_link(l));
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_STIFFNESS) stiffness_reg = value[ST_W-1:0];
    else tear_reg = value[TEAR_W-1:0];
    @(posedge clk);
  endtask

  function automatic link_t make_link(int a1, int a2, int b1, int b2, int za, int zb,
                                      int m1, int m2, int rest);
    link_t l;
    l.p1 = '{pos_t'(a1), pos_t'(a2), pos_t'(za)};
    l.p2 = '{pos_t'(b1), pos_t'(b2), pos_t'(zb)};
    l.m1 = mass_t'(m1);
    l.m2 = mass_t'(m2);
    l.rest = rest_t'(rest);
    return l;
  endfunction

  function automatic link_t random_link();
    link_t l;
    int span;
    int kind;
    kind = $urandom_range(9);
    span = (kind < 4) ? 32'h7fffffff : (1 << $urandom_range(4, 26));
    for (int i = 0; i < 3; i++) begin
      l.p1[i] = pos_t'($urandom);
      if (kind < 4) l.p2[i] = pos_t'($urandom);
      else l.p2[i] = l.p1[i] + pos_t'($urandom_range(0, span)) - pos_t'(span / 2);
    end
    if (kind == 9) begin
      l.p2[0] = l.p1[0];
      l.p2[1] = l.p1[1];
    end
    l.m1 = mass_t'($urandom_range(1, 65535));
    l.m2 = mass_t'($urandom_range(1, 65535));
    l.rest = $urandom_range(1) ? rest_t'($urandom) : rest_t'($urandom_range(0, span));
    return l;
  endfunction

  task automatic test_directed();
    link_t cases[$];
    cases.push_back(make_link(0, 0, 0, 0, 5, -5, 256, 256, 65536));
    cases.push_back(make_link(65536, 0, 0, 0, 0, 0, 256, 256, 131072));
    cases.push_back(make_link(65536, 0, 0, 0, 0, 0, 256, 256, 0));
    cases.push_back(make_link(32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000,
                              32'h7fffffff, 32'h80000000, 1, 65535, 0));
    cases.push_back(make_link(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
                              32'h80000000, 32'h7fffffff, 65535, 1, 32'h7fffffff));
    cases.push_back(make_link(0, 1, 0, 0, 0, 0, 1, 1, 32'h7fffffff));
    cases.push_back(make_link(1, 1, 0, 0, 32'h7fffffff, 32'h80000000, 65535, 65535, 0));
    cases.push_back(make_link(3, 4, 0, 0, 9, -9, 300, 100, 5));
    cases.push_back(make_link(-3, -4, 0, 0, 0, 0, 100, 300, 10));
    cases.push_back(make_link(100000, -200000, -100000, 200000, 7, 7, 256, 512, 65536));
    cases.push_back(make_link(32'h7fffffff, 0, 0, 0, 0, 32'h7fffffff, 1, 1, 32'h7fffffff));
    cases.push_back(make_link(0, 32'h80000000, 0, 32'h7fffffff, 0, 0, 2, 1, 1));
    cases.push_back(make_link(12345, 12345, 12345, 12345, 0, 32'h80000000, 1, 1, 0));
    cases.push_back(make_link(65536, 3, 0, -7, 11, 2, 0, 256, 0));
    cases.push_back(make_link(-65536, 3, 0, -7, 11, 2, 512, 0, 131072));
    cases.push_back(make_link(65536, 65536, 0, 0, 1, 2, 0, 0, 0));
    foreach (cases[i]) send_link(cases[i]);
    wait_idle();
    write_reg(CFG_TEAR, 31'd0);
    foreach (cases[i]) send_link(cases[i]);
    wait_idle();
  endtask

  task automatic test_random(int count, int s_idle, int r_idle);
    send_idle = s_idle;
    recv_idle = r_idle;
    repeat (count) send_link(random_link());
    wait_idle();
  endtask

  task automatic test_output_stall();
    send_idle = 0;
    recv_idle = 0;
    hold_left = 400;
    repeat (200) send_link(random_link());
    wait_idle();
  endtask

  initial begin
    stiffness_reg = ST_RESET;
    tear_reg = TEAR_RESET;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    write_reg(CFG_STIFFNESS, 31'd0);
    write_reg(CFG_TEAR, 31'h7fffffff);
    test_random(100, 32, 71);
    write_reg(CFG_STIFFNESS, 31'd131071);
    write_reg(CFG_TEAR, 31'd0);
    test_random(150, 71, 32);
    write_reg(CFG_STIFFNESS, CFG_W'($urandom_range(0, 131071)));
    write_reg(CFG_TEAR, CFG_W'($urandom_range(0, 1 << 22)));
    test_random(300, 0, 0);
    write_reg(CFG_STIFFNESS, 31'd65536);
    test_output_stall();
    write_reg(CFG_STIFFNESS, CFG_W'($urandom_range(0, 131071)));
    write_reg(CFG_TEAR, CFG_W'($urandom));
    test_random(200, 32, 71);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
